// File: src/jsu_pkg.sv
package jsu_pkg;

  localparam int unsigned CapW    = 11;
  localparam int unsigned LenW    = 10;
  localparam int unsigned CntW    = 13;
  localparam int unsigned AccW    = 16;
  localparam logic [CapW-1:0] MaxCapacity = 11'd1024;
  localparam logic [CapW-1:0] CapacityReset = 11'd640;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLetterN   = 8'h6E;
  localparam logic [7:0] ChLetterT   = 8'h74;
  localparam logic [7:0] ChLetterR   = 8'h72;
  localparam logic [7:0] ChLetterB   = 8'h62;
  localparam logic [7:0] ChLetterF   = 8'h66;
  localparam logic [7:0] ChLetterU   = 8'h75;
  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChQuestion  = 8'h3F;
  localparam logic [AccW-1:0] PrintLow  = 16'h0020;
  localparam logic [AccW-1:0] PrintHigh = 16'h007F;

  typedef enum logic [1:0] {
    KindChar = 2'd0,
    KindDone = 2'd1,
    KindErr  = 2'd2
  } kind_e;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [CntW-1:0] consumed;
    logic [LenW-1:0] len;
    logic [7:0]      ch;
    kind_e           kind;
  } result_t;

  // bit 4 set when the byte is a hex digit, low nibble its value
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

// File: src/jsu_in_stage.sv
module jsu_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  jsu_pkg::in_item_t item_i,
  input  logic              take_i,
  output logic              valid_o,
  output jsu_pkg::in_item_t item_o
);

  logic              valid_q, valid_d;
  jsu_pkg::in_item_t item_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) valid_d = 1'b0;
    if (valid_i && ready_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: src/jsu_decode.sv
module jsu_decode (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [jsu_pkg::CapW-1:0]  cfg_wdata_i,
  input  logic                      valid_i,
  input  jsu_pkg::in_item_t         item_i,
  output logic                      take_o,
  output logic                      res_valid_o,
  output jsu_pkg::result_t          res_o,
  input  logic                      res_ready_i
);

  localparam logic [1:0] ModeIdle  = 2'd0;
  localparam logic [1:0] ModePlain = 2'd1;
  localparam logic [1:0] ModeEsc   = 2'd2;
  localparam logic [1:0] ModeHex   = 2'd3;

  logic [jsu_pkg::CapW-1:0] cap_q;
  logic [1:0]               mode_q, mode_d;
  logic [1:0]               hd_q, hd_d;
  logic [jsu_pkg::AccW-1:0] hx_q, hx_d;
  logic [jsu_pkg::LenW-1:0] oc_q, oc_d;
  logic [jsu_pkg::CntW-1:0] bc_q, bc_d;
  logic                     out_valid_q, out_valid_d;
  jsu_pkg::result_t         out_q;

  logic [1:0]               mode_cur;
  logic [1:0]               hd_cur;
  logic [jsu_pkg::AccW-1:0] hx_cur;
  logic [jsu_pkg::LenW-1:0] oc_cur;
  logic [jsu_pkg::CntW-1:0] bc_cur;
  logic [jsu_pkg::CapW-1:0] cap_eff;
  logic                     room;
  logic                     want_emit;
  logic                     fin;
  jsu_pkg::kind_e           fin_kind;
  logic [7:0]               emit_ch;
  logic [4:0]               hv;
  logic                     has_res;
  jsu_pkg::result_t         res_d;
  logic [7:0]               b;

  assign b       = item_i.data;
  assign cap_eff = (cap_q > jsu_pkg::MaxCapacity) ? jsu_pkg::MaxCapacity : cap_q;
  assign room    = ({1'b0, oc_cur} + jsu_pkg::CapW'(1)) < cap_eff;
  assign hv      = jsu_pkg::hex_value(b);

  always_comb begin
    mode_cur = item_i.start ? ModePlain : mode_q;
    hd_cur   = item_i.start ? 2'd0 : hd_q;
    hx_cur   = item_i.start ? '0 : hx_q;
    oc_cur   = item_i.start ? '0 : oc_q;
    bc_cur   = item_i.start ? '0 : bc_q;

    mode_d    = mode_cur;
    hd_d      = hd_cur;
    hx_d      = hx_cur;
    bc_d      = bc_cur;
    want_emit = 1'b0;
    fin       = 1'b0;
    fin_kind  = jsu_pkg::KindErr;
    emit_ch   = b;

    if (mode_cur != ModeIdle) begin
      if (bc_cur != {jsu_pkg::CntW{1'b1}}) bc_d = bc_cur + jsu_pkg::CntW'(1);
      if (b == 8'h00) begin
        fin = 1'b1;
      end else begin
        unique case (mode_cur)
          ModePlain: begin
            if (b == jsu_pkg::ChQuote) begin
              fin      = 1'b1;
              fin_kind = jsu_pkg::KindDone;
            end else if (b == jsu_pkg::ChBackslash) begin
              mode_d = ModeEsc;
            end else begin
              want_emit = 1'b1;
            end
          end
          ModeEsc: begin
            mode_d = ModePlain;
            if (b == jsu_pkg::ChLetterN) begin
              want_emit = 1'b1;
              emit_ch   = jsu_pkg::ChNewline;
            end else if (b == jsu_pkg::ChLetterT) begin
              want_emit = 1'b1;
              emit_ch   = jsu_pkg::ChSpace;
            end else if (b == jsu_pkg::ChLetterR || b == jsu_pkg::ChLetterB ||
                         b == jsu_pkg::ChLetterF) begin
              want_emit = 1'b0;
            end else if (b == jsu_pkg::ChLetterU) begin
              mode_d = ModeHex;
              hd_d   = 2'd0;
              hx_d   = '0;
            end else begin
              want_emit = 1'b1;
            end
          end
          ModeHex: begin
            if (!hv[4]) begin
              fin = 1'b1;
            end else begin
              hx_d = {hx_cur[jsu_pkg::AccW-5:0], hv[3:0]};
              if (hd_cur != 2'd3) begin
                hd_d = hd_cur + 2'd1;
              end else begin
                hd_d      = 2'd0;
                mode_d    = ModePlain;
                want_emit = 1'b1;
                emit_ch   = (hx_d >= jsu_pkg::PrintLow && hx_d < jsu_pkg::PrintHigh) ?
                            hx_d[7:0] : jsu_pkg::ChQuestion;
              end
            end
          end
          default: begin
            mode_d = ModeIdle;
          end
        endcase
      end
      if (fin) mode_d = ModeIdle;
    end

    oc_d = (want_emit && room) ? oc_cur + jsu_pkg::LenW'(1) : oc_cur;
    has_res = fin || (want_emit && room);

    res_d.kind     = fin ? fin_kind : jsu_pkg::KindChar;
    res_d.ch       = fin ? 8'h00 : emit_ch;
    res_d.len      = oc_d;
    res_d.consumed = bc_d;
  end

  // an item with no result need not wait for the output slot
  assign take_o = valid_i && (!has_res || !out_valid_q || res_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_ready_i) out_valid_d = 1'b0;
    if (take_o && has_res) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= jsu_pkg::CapacityReset;
      mode_q      <= ModeIdle;
      hd_q        <= 2'd0;
      hx_q        <= '0;
      oc_q        <= '0;
      bc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (take_o) begin
        mode_q <= mode_d;
        hd_q   <= hd_d;
        hx_q   <= hx_d;
        oc_q   <= oc_d;
        bc_q   <= bc_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && has_res) begin
      out_q <= res_d;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

`ifndef ASSERT_OFF
  a_char_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == jsu_pkg::KindChar |-> out_q.len != '0)
    else $error("character result with zero stored length");
  a_consumed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.consumed != '0)
    else $error("result with zero consumed count");
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o && has_res && fin |=> mode_q == ModeIdle)
    else $error("decoder not idle after end of string");
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.kind == jsu_pkg::KindChar || out_q.kind == jsu_pkg::KindDone ||
                     out_q.kind == jsu_pkg::KindErr))
    else $error("result with unknown kind");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_ready_i |=> out_valid_q && $stable(out_q))
    else $error("pending result overwritten");
`endif

endmodule

// File: src/json_string_unescape.sv
// JSON string body decoder.
// Slave stream: one raw byte per item in s_axis_tdata_i; s_axis_tuser_i marks
// the first byte after an opening quote and clears the decoder state.
// Master stream: at most one result per input item. m_axis_tuser_o holds the
// kind (character, string closed, malformed); m_axis_tdata_o holds the
// character, the stored length and the consumed byte count.
// cfg_we_i/cfg_wdata_i write the output buffer capacity (reset 640); write it
// only while no string is in flight.
// An accepted item is held in the input register, then decoded into the
// result register; a held result can keep it waiting in the input register.
// Throughput: one item per cycle unless a held result blocks the input; the
// state update for a byte is a single pass of logic between the input
// register and the result register. Bytes that give no result (escape prefixes,
// dropped escapes, characters past capacity, bytes while idle) are still taken.
// Reset clears the decoder to idle, empties both registers and restores the
// capacity; bytes arriving before a start marker are ignored.
// When the receiver stalls the result is held; items without a result keep
// flowing, and once an item with a result sits in the input register,
// s_axis_tready_o drops until the held result moves on.
module json_string_unescape (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,    // capacity
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i, // [7:0] in_byte
  input  logic        s_axis_tuser_i, // [0] start_req
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o, // [7:0] char_value, [17:8] stored_length,
                                      // [30:18] consumed, [31] zero
  output logic [1:0]  m_axis_tuser_o  // [1:0] kind
);

  jsu_pkg::in_item_t in_item;
  jsu_pkg::in_item_t dec_item;
  jsu_pkg::result_t  res;
  logic              dec_valid;
  logic              dec_take;

  assign in_item.start = s_axis_tuser_i;
  assign in_item.data  = s_axis_tdata_i;

  jsu_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .take_i  (dec_take),
    .valid_o (dec_valid),
    .item_o  (dec_item)
  );

  jsu_decode u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (dec_valid),
    .item_i      (dec_item),
    .take_o      (dec_take),
    .res_valid_o (m_axis_tvalid_o),
    .res_o       (res),
    .res_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {1'b0, res.consumed, res.len, res.ch};
  assign m_axis_tuser_o = res.kind;

endmodule
